FILE: design/toas_pkg.sv
// Package with shared types, constants and state encodings for the activity scheduler.
package toas_pkg;

    localparam int SLOTS        = 16;
    localparam int TIME_BITS    = 48;
    localparam int PAYLOAD_BITS = 32;
    localparam int IDX_BITS     = $clog2(SLOTS);
    localparam int LINK_BITS    = IDX_BITS + 1;
    localparam int COUNT_BITS   = 5;

    localparam logic [LINK_BITS-1:0] NULL_LINK = LINK_BITS'(SLOTS);

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic [TIME_BITS-1:0]    item_timestamp;
        logic [PAYLOAD_BITS-1:0] item_data;
        logic [TIME_BITS-1:0]    now_time;
    } t_req;

    typedef struct packed {
        logic [1:0]              status;
        logic [TIME_BITS-1:0]    out_timestamp;
        logic [PAYLOAD_BITS-1:0] out_data;
        logic [COUNT_BITS-1:0]   entry_count;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_WALK_RD,
        S_WALK_CMP,
        S_LINK,
        S_POP_RD,
        S_POP_CMP,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic find_init;
        logic find_step;
        logic walk_init;
        logic walk_read;
        logic walk_adv;
        logic commit_push;
        logic pop_read;
        logic commit_pop;
        logic rsp_full;
        logic rsp_none;
        logic rsp_ok_push;
        logic rsp_ok_pop;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_pop;
        logic full;
        logic empty;
        logic find_hit;
        logic find_last;
        logic walk_end;
        logic walk_go;
        logic pop_due;
    } t_stat;

endpackage

FILE: design/toas_ctrl.sv
// Controller state machine that sequences push and pop transactions.
module toas_ctrl import toas_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.is_pop) begin
                    if (i_stat.empty) begin
                        o_cmd.rsp_none = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        o_cmd.pop_read = 1'b1;
                        n_state        = S_POP_RD;
                    end
                end else if (i_stat.full) begin
                    o_cmd.rsp_full = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.find_init = 1'b1;
                    n_state         = S_FIND;
                end
            end
            S_FIND: begin
                if (i_stat.find_hit) begin
                    o_cmd.walk_init = 1'b1;
                    n_state         = S_WALK_RD;
                end else if (i_stat.find_last) begin
                    o_cmd.rsp_full = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.find_step = 1'b1;
                end
            end
            S_WALK_RD: begin
                if (i_stat.walk_end) begin
                    n_state = S_LINK;
                end else begin
                    o_cmd.walk_read = 1'b1;
                    n_state         = S_WALK_CMP;
                end
            end
            S_WALK_CMP: begin
                if (i_stat.walk_go) begin
                    o_cmd.walk_adv = 1'b1;
                    n_state        = S_WALK_RD;
                end else begin
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                o_cmd.commit_push = 1'b1;
                o_cmd.rsp_ok_push = 1'b1;
                n_state           = S_IDLE;
            end
            S_POP_RD: begin
                n_state = S_POP_CMP;
            end
            S_POP_CMP: begin
                if (i_stat.pop_due) begin
                    o_cmd.commit_pop = 1'b1;
                    o_cmd.rsp_ok_pop = 1'b1;
                end else begin
                    o_cmd.rsp_none = 1'b1;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/toas_dp.sv
// Datapath with the slot memories, list pointers and result register.
module toas_dp import toas_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_req  i_req,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output logic  o_strobe,
    output t_rsp  o_rsp
);

    logic [TIME_BITS-1:0]    r_mem_time [SLOTS];
    logic [PAYLOAD_BITS-1:0] r_mem_data [SLOTS];
    logic [LINK_BITS-1:0]    r_mem_next [SLOTS];
    logic [SLOTS-1:0]        r_busy;
    logic [LINK_BITS-1:0]    r_head;
    logic [COUNT_BITS-1:0]   r_count;
    logic [IDX_BITS-1:0]     r_alloc;

    t_req                    r_req;
    logic [IDX_BITS-1:0]     r_find;
    logic [IDX_BITS:0]       r_tries;
    logic [LINK_BITS-1:0]    r_before;
    logic [LINK_BITS-1:0]    r_after;
    logic [IDX_BITS:0]       r_steps;
    logic [TIME_BITS-1:0]    r_rd_time;
    logic [PAYLOAD_BITS-1:0] r_rd_data;
    logic [LINK_BITS-1:0]    r_rd_next;
    logic                    r_strobe;
    t_rsp                    r_rsp;
    t_rsp                    n_rsp;

    logic [IDX_BITS-1:0] w_after_idx;
    logic [IDX_BITS-1:0] w_head_idx;
    logic [IDX_BITS-1:0] w_before_idx;

    assign w_after_idx  = r_after[IDX_BITS-1:0];
    assign w_head_idx   = r_head[IDX_BITS-1:0];
    assign w_before_idx = r_before[IDX_BITS-1:0];

    assign o_stat.is_pop    = (r_req.req_type == REQ_POP);
    assign o_stat.full      = (r_count >= COUNT_BITS'(SLOTS));
    assign o_stat.empty     = (r_count == '0) || (r_head >= NULL_LINK);
    assign o_stat.find_hit  = !r_busy[r_find];
    assign o_stat.find_last = (r_tries == (IDX_BITS+1)'(SLOTS - 1));
    assign o_stat.walk_end  = (r_after >= NULL_LINK) || (r_steps == (IDX_BITS+1)'(SLOTS));
    assign o_stat.walk_go   = (r_rd_time <= r_req.item_timestamp);
    assign o_stat.pop_due   = (r_rd_time <= r_req.now_time);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.find_init) begin
            r_find  <= r_alloc;
            r_tries <= '0;
        end else if (i_cmd.find_step) begin
            r_find  <= r_find + 1'b1;
            r_tries <= r_tries + 1'b1;
        end
        if (i_cmd.walk_init) begin
            r_before <= NULL_LINK;
            r_after  <= r_head;
            r_steps  <= '0;
        end else if (i_cmd.walk_adv) begin
            r_before <= r_after;
            r_after  <= (r_rd_next >= NULL_LINK) ? NULL_LINK : r_rd_next;
            r_steps  <= r_steps + 1'b1;
        end
        if (i_cmd.walk_read) begin
            r_rd_time <= r_mem_time[w_after_idx];
            r_rd_next <= r_mem_next[w_after_idx];
        end else if (i_cmd.pop_read) begin
            r_rd_time <= r_mem_time[w_head_idx];
            r_rd_data <= r_mem_data[w_head_idx];
            r_rd_next <= r_mem_next[w_head_idx];
        end
        if (i_cmd.commit_push) begin
            r_mem_time[r_find] <= r_req.item_timestamp;
            r_mem_data[r_find] <= r_req.item_data;
            r_mem_next[r_find] <= r_after;
            if (r_before < NULL_LINK) begin
                r_mem_next[w_before_idx] <= {1'b0, r_find};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= '0;
            r_head   <= NULL_LINK;
            r_count  <= '0;
            r_alloc  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.rsp_full | i_cmd.rsp_none | i_cmd.rsp_ok_push | i_cmd.rsp_ok_pop;
            if (i_cmd.commit_push) begin
                r_busy[r_find] <= 1'b1;
                r_alloc        <= r_find + 1'b1;
                r_count        <= r_count + 1'b1;
                if (r_before >= NULL_LINK) begin
                    r_head <= {1'b0, r_find};
                end
            end
            if (i_cmd.commit_pop) begin
                r_busy[w_head_idx] <= 1'b0;
                r_head             <= (r_rd_next >= NULL_LINK) ? NULL_LINK : r_rd_next;
                r_count            <= r_count - 1'b1;
            end
        end
    end

    always_comb begin
        n_rsp             = '0;
        n_rsp.status      = ST_OK;
        n_rsp.entry_count = r_count;
        if (i_cmd.rsp_full) begin
            n_rsp.status = ST_FULL;
        end else if (i_cmd.rsp_none) begin
            n_rsp.status = ST_NONE;
        end else if (i_cmd.rsp_ok_push) begin
            n_rsp.entry_count = r_count + 1'b1;
        end else if (i_cmd.rsp_ok_pop) begin
            n_rsp.out_timestamp = r_rd_time;
            n_rsp.out_data      = r_rd_data;
            n_rsp.entry_count   = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

FILE: design/time_ordered_activity_scheduler.sv
// Top level of the time-ordered activity scheduler.
//   Channel   Handshake           Payload
//   request   start, busy         i_req (t_req)
//   result    o_valid strobe      o_rsp (t_rsp)
// A pop reads the head entry and returns it if its time is not after now_time;
// an empty store gives no entry. A push answers full when the store is full, else
// it probes slots for a free one, then walks the list and links the new entry.
// Synchronous active-low reset empties the store at once.
// The result appears for one cycle and busy falls with it.
module time_ordered_activity_scheduler import toas_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_valid,
    output t_rsp o_rsp
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_busy;
    logic  w_start;

    assign w_start = start & ~o_valid;

    toas_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (w_busy)
    );

    toas_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_strobe (o_valid),
        .o_rsp    (o_rsp)
    );

    assign busy = w_busy | o_valid;

endmodule

FILE: design/toas_checker.sv
// Port-level checker for the activity scheduler, bound to the top level.
module toas_checker import toas_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input t_rsp o_rsp
);

    a_no_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_valid) else $error("result in cycle after accept");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result while not busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.entry_count <= COUNT_BITS'(SLOTS))) else $error("count range");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status != ST_OK) |-> (o_rsp.out_timestamp == '0 && o_rsp.out_data == '0))
        else $error("fields not zero on failure");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("strobe longer than one cycle");

endmodule

bind time_ordered_activity_scheduler toas_checker u_toas_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_rsp   (o_rsp)
);
